// ===== src/htd_pkg.sv =====
// ----------------------------------------------------------------------------
// htd_pkg
// Shared widths, register codes, constants and the segment font for the
// hysteresis thermostat display block.
// ----------------------------------------------------------------------------
`default_nettype none

package htd_pkg;

   // Converter resolution and field widths
   localparam int ADC_BITS   = 10;
   localparam int SAMPLE_W   = 10;
   localparam int TEMP_W     = 14;
   localparam int HYST_W     = 10;
   localparam int DUTY_W     = 8;
   localparam int DEC_W      = 8;
   localparam int SEG_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   // Full-scale temperature in hundredths of a degree
   localparam logic [TEMP_W-1:0] TEMP_SCALE = 14'd11000;

   // Register reset values
   localparam logic [TEMP_W-1:0] SETPOINT_RESET = 14'd8000;
   localparam logic [HYST_W-1:0] HYST_RESET     = 10'd100;
   localparam logic [DUTY_W-1:0] ON_DUTY_RESET  = 8'd225;
   localparam logic [DEC_W-1:0]  DEC_RESET      = 8'd15;

   // Reciprocals for the decimal split; exact for any 14-bit value
   localparam logic [16:0] RECIP_10   = 17'd52429;  // 2^19 / 10
   localparam logic [12:0] RECIP_100  = 13'd5243;   // 2^19 / 100
   localparam logic [13:0] RECIP_1000 = 14'd8389;   // 2^23 / 1000

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT   = 2'd0,
      CSR_HYSTERESIS = 2'd1,
      CSR_ON_DUTY    = 2'd2,
      CSR_DECIMATION = 2'd3
   } csr_index_type;

   // Control result handed to the pipeline register
   typedef struct packed {
      logic              taken;
      logic [TEMP_W-1:0] temp;
      logic [DUTY_W-1:0] duty;
   } ctrl_result_type;

   // Segment bits of one active-low digit group
   typedef struct packed {
      logic [SEG_W-1:0] tens;
      logic [SEG_W-1:0] units;
      logic [SEG_W-1:0] tenths;
      logic [SEG_W-1:0] hundredths;
   } seg_group_type;

   localparam logic [SEG_W-1:0] SEG_POINT = 8'h80;

   // Active-high segment pattern of one decimal digit, bit0 is segment a
   function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] digit);
      logic [SEG_W-1:0] pat;
      case (digit)
         4'd0:    pat = 8'b00111111;
         4'd1:    pat = 8'b00000110;
         4'd2:    pat = 8'b01011011;
         4'd3:    pat = 8'b01001111;
         4'd4:    pat = 8'b01100110;
         4'd5:    pat = 8'b01101101;
         4'd6:    pat = 8'b01111101;
         4'd7:    pat = 8'b00000111;
         4'd8:    pat = 8'b01111111;
         4'd9:    pat = 8'b01101111;
         default: pat = 8'b00000000;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

// ===== src/htd_req_if.sv =====
// ----------------------------------------------------------------------------
// htd_req_if
// Sample channel: valid/ready handshake carrying one raw converter word.
// ----------------------------------------------------------------------------
`default_nettype none

interface htd_req_if;
   import htd_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

`default_nettype wire

// ===== src/htd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// htd_rsp_if
// Result channel: valid/ready handshake carrying temperature, duty and the
// four display digits.
// ----------------------------------------------------------------------------
`default_nettype none

interface htd_rsp_if;
   import htd_pkg::*;

   logic              valid;
   logic              ready;
   logic              sample_taken;
   logic [TEMP_W-1:0] temperature_centi;
   logic [DUTY_W-1:0] lamp_duty;
   logic [SEG_W-1:0]  seg_tens;
   logic [SEG_W-1:0]  seg_units;
   logic [SEG_W-1:0]  seg_tenths;
   logic [SEG_W-1:0]  seg_hundredths;

   modport source (output valid, output sample_taken, output temperature_centi,
                   output lamp_duty, output seg_tens, output seg_units,
                   output seg_tenths, output seg_hundredths, input ready);
   modport sink   (input valid, input sample_taken, input temperature_centi,
                   input lamp_duty, input seg_tens, input seg_units,
                   input seg_tenths, input seg_hundredths, output ready);
endinterface

`default_nettype wire

// ===== src/hysteresis_thermostat_display_top.sv =====
// ----------------------------------------------------------------------------
// hysteresis_thermostat_display_top
// Thermostat with hysteresis and a four-digit seven-segment readout.
//
// Channels: req_ch takes one raw converter word per handshake; rsp_ch gives
// one word per accepted sample: a used-sample flag, the last used temperature
// in hundredths of a degree, the lamp duty and four active-low digits.
// csr_we/csr_index/csr_wdata write the setpoint, hysteresis, on duty and
// decimation; write them only while the block holds no words in flight.
//
// From accept to rsp_ch.valid, the control stage updates the thermostat
// state and registers its result, then the display stage splits the
// temperature into digits into the output register. Throughput is one
// word per cycle while rsp_ch.ready stays high; the single
// multiply-and-compare control stage sets that figure.
//
// Reset clears the sample counter, temperature and duty to zero and loads
// the register reset values. When the receiver stalls, the output register
// holds its word and the control register keeps taking one more; req_ch.ready
// drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module hysteresis_thermostat_display_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   htd_req_if.sink                             req_ch,
   htd_rsp_if.source                           rsp_ch,
   input  wire logic                           csr_we,
   input  wire logic [htd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [htd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import htd_pkg::*;

   ctrl_result_type ctrl_result;
   ctrl_result_type stage_ff;
   logic            stage_valid_ff, stage_valid_in;
   logic            out_valid_ff, out_valid_in;
   logic            out_load;
   logic            accept;
   seg_group_type   segs;
   logic            taken_ff;
   logic [TEMP_W-1:0] temp_ff;
   logic [DUTY_W-1:0] duty_ff;
   seg_group_type   segs_ff;

   // Handshake flow
   assign out_load     = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !stage_valid_ff || out_load;
   assign accept       = req_ch.valid && req_ch.ready;

   htd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .step       (accept),
      .adc_sample (req_ch.adc_sample),
      .result     (ctrl_result)
   );

   htd_seg_encode u_seg_encode (
      .temp (stage_ff.temp),
      .segs (segs)
   );

   // Advance valid flags
   always_comb begin
      stage_valid_in = stage_valid_ff;
      out_valid_in   = out_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (out_load) begin
         stage_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Capture control result on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= ctrl_result;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (out_load && stage_valid_ff) begin
         taken_ff <= stage_ff.taken;
         temp_ff  <= stage_ff.temp;
         duty_ff  <= stage_ff.duty;
         segs_ff  <= segs;
      end
   end

   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.sample_taken      = taken_ff;
   assign rsp_ch.temperature_centi = temp_ff;
   assign rsp_ch.lamp_duty         = duty_ff;
   assign rsp_ch.seg_tens          = segs_ff.tens;
   assign rsp_ch.seg_units         = segs_ff.units;
   assign rsp_ch.seg_tenths        = segs_ff.tenths;
   assign rsp_ch.seg_hundredths    = segs_ff.hundredths;

   // A full control stage facing a stalled output must hold its word
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !out_load) |=> (stage_valid_ff && $stable(stage_ff)))
      else $error("control stage word lost under stall");

   // Never accept into a full control stage that cannot drain
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!stage_valid_ff || out_load))
      else $error("sample accepted into a blocked control stage");

   // A drained control stage becomes the output word next cycle
   a_stage_to_out: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && out_load) |=> out_valid_ff)
      else $error("control stage word not moved to output");

endmodule

`default_nettype wire

// ===== src/htd_ctrl.sv =====
// ----------------------------------------------------------------------------
// htd_ctrl
// Control registers, sample decimation, temperature scaling and the
// hysteresis switch of the lamp duty.
// ----------------------------------------------------------------------------
`default_nettype none

module htd_ctrl (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [htd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [htd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                               step,
   input  wire logic [htd_pkg::SAMPLE_W-1:0]       adc_sample,
   output htd_pkg::ctrl_result_type                result
);
   import htd_pkg::*;

   logic [TEMP_W-1:0]          setpoint_ff;
   logic [HYST_W-1:0]          hyst_ff;
   logic [DUTY_W-1:0]          on_duty_ff;
   logic [DEC_W-1:0]           dec_ff;
   logic [DEC_W-1:0]           count_ff, count_in;
   logic [TEMP_W-1:0]          temp_ff, temp_in;
   logic [DUTY_W-1:0]          duty_ff, duty_in;
   logic [DEC_W-1:0]           count_next;
   logic                       taken;
   logic [ADC_BITS+TEMP_W-1:0] scaled;
   logic [TEMP_W-1:0]          new_temp;
   logic [TEMP_W:0]            low_sum;
   logic [TEMP_W:0]            high_edge;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= SETPOINT_RESET;
         hyst_ff     <= HYST_RESET;
         on_duty_ff  <= ON_DUTY_RESET;
         dec_ff      <= DEC_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SETPOINT:   setpoint_ff <= csr_wdata[TEMP_W-1:0];
            CSR_HYSTERESIS: hyst_ff     <= csr_wdata[HYST_W-1:0];
            CSR_ON_DUTY:    on_duty_ff  <= csr_wdata[DUTY_W-1:0];
            CSR_DECIMATION: dec_ff      <= csr_wdata[DEC_W-1:0];
            default: ;
         endcase
      end
   end

   // Count samples; use one once the count reaches the decimation
   assign count_next = count_ff + 1'b1;
   assign taken      = (count_next >= dec_ff);

   // Scale the sample to hundredths of a degree
   assign scaled   = (ADC_BITS+TEMP_W)'(adc_sample[ADC_BITS-1:0])
                     * (ADC_BITS+TEMP_W)'(TEMP_SCALE);
   assign new_temp = scaled[ADC_BITS+TEMP_W-1:ADC_BITS];

   // Band edges, kept unsigned: t < sp - hy is t + hy < sp
   assign low_sum   = (TEMP_W+1)'(new_temp) + (TEMP_W+1)'(hyst_ff);
   assign high_edge = (TEMP_W+1)'(setpoint_ff) + (TEMP_W+1)'(hyst_ff);

   always_comb begin
      count_in = count_ff;
      temp_in  = temp_ff;
      duty_in  = duty_ff;
      if (step) begin
         count_in = taken ? '0 : count_next;
         if (taken) begin
            temp_in = new_temp;
            if (low_sum < (TEMP_W+1)'(setpoint_ff)) begin
               duty_in = on_duty_ff;
            end else if ((TEMP_W+1)'(new_temp) > high_edge) begin
               duty_in = '0;
            end
         end
      end
   end

   // Register the sample counter; hold temperature and duty between used samples
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         temp_ff  <= '0;
         duty_ff  <= '0;
      end else begin
         count_ff <= count_in;
         temp_ff  <= temp_in;
         duty_ff  <= duty_in;
      end
   end

   assign result.taken = step && taken;
   assign result.temp  = temp_in;
   assign result.duty  = duty_in;

   // A used sample clears the counter
   a_count_clears: assert property (@(posedge clock) disable iff (reset)
      (step && taken) |=> (count_ff == '0))
      else $error("sample counter not cleared after a used sample");

   // Temperature changes only on a used sample
   a_temp_holds: assert property (@(posedge clock) disable iff (reset)
      !(step && taken) |=> $stable(temp_ff))
      else $error("temperature changed without a used sample");

   // Duty changes only on a used sample
   a_duty_holds: assert property (@(posedge clock) disable iff (reset)
      !(step && taken) |=> $stable(duty_ff))
      else $error("duty changed without a used sample");

endmodule

`default_nettype wire

// ===== src/htd_seg_encode.sv =====
// ----------------------------------------------------------------------------
// htd_seg_encode
// Split a temperature in hundredths into four decimal digits and map them
// to active-low seven-segment patterns, decimal point lit on the units digit.
// ----------------------------------------------------------------------------
`default_nettype none

module htd_seg_encode (
   input  wire logic [htd_pkg::TEMP_W-1:0] temp,
   output htd_pkg::seg_group_type          segs
);
   import htd_pkg::*;

   logic [30:0]       prod_10;
   logic [26:0]       prod_100;
   logic [27:0]       prod_1000;
   logic [10:0]       q10;
   logic [6:0]        q100;
   logic [3:0]        q1000;
   logic [TEMP_W-1:0] rem_0;
   logic [10:0]       rem_1;
   logic [6:0]        rem_2;
   logic [3:0]        d_tens;

   // Quotients by reciprocal multiplication
   assign prod_10   = 31'(temp) * 31'(RECIP_10);
   assign prod_100  = 27'(temp) * 27'(RECIP_100);
   assign prod_1000 = 28'(temp) * 28'(RECIP_1000);
   assign q10       = prod_10[29:19];
   assign q100      = prod_100[25:19];
   assign q1000     = prod_1000[26:23];

   // Digits as differences of neighboring quotients
   assign rem_0  = temp - (14'(q10) * 14'd10);
   assign rem_1  = q10 - (11'(q100) * 11'd10);
   assign rem_2  = q100 - (7'(q1000) * 7'd10);
   assign d_tens = (q1000 >= 4'd10) ? (q1000 - 4'd10) : q1000;

   // Map to active-low segments
   assign segs.tens       = ~seg_font(d_tens);
   assign segs.units      = ~(seg_font(rem_2[3:0]) | SEG_POINT);
   assign segs.tenths     = ~seg_font(rem_1[3:0]);
   assign segs.hundredths = ~seg_font(rem_0[3:0]);

endmodule

`default_nettype wire
